// ----- rtl/core/u16u8_pkg.sv -----
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared widths, constants and types of the UTF-16LE to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam int unsigned UnitW      = 16;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CapW       = 12;
  localparam int unsigned PayloadW   = 10;
  localparam int unsigned CpW        = 21;
  localparam int unsigned MaxChar    = 4;
  localparam int unsigned MaxRes     = MaxChar + 1;
  localparam int unsigned CntW       = $clog2(MaxRes + 1);
  localparam int unsigned BudgetLimit = 4096;
  localparam int unsigned BudgetW    = $clog2(BudgetLimit);

  localparam logic [BudgetW-1:0] BudgetMax   = BudgetW'(BudgetLimit - 1);
  localparam logic [BudgetW-1:0] BudgetFloor = BudgetW'(6);
  localparam logic [CapW-1:0]    CapReset    = CapW'(512);

  // Surrogate window on the high byte of a unit, and UTF-8 markers
  localparam logic [7:0]     SurrFirst = 8'hD8;
  localparam logic [7:0]     SurrEnd   = 8'hE0;
  localparam logic [CpW-1:0] PlaneBase = CpW'(32'h10000);
  localparam logic [CpW-1:0] Max1Byte  = CpW'(32'h7F);
  localparam logic [CpW-1:0] Max2Byte  = CpW'(32'h7FF);
  localparam logic [CpW-1:0] Max3Byte  = CpW'(32'hFFFF);
  localparam logic [7:0]     Lead2     = 8'hC0;
  localparam logic [7:0]     Lead3     = 8'hE0;
  localparam logic [7:0]     Lead4     = 8'hF0;
  localparam logic [7:0]     ContMark  = 8'h80;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             last_unit;
    logic             reload_budget;
  } u16u8_item_t;

  typedef struct packed {
    logic                pend_valid;
    logic [PayloadW-1:0] pend_hi;
    logic [BudgetW-1:0]  budget;
  } u16u8_state_t;

  typedef struct packed {
    logic [MaxRes-1:0][ByteW-1:0] bytes;
    logic [CntW-1:0]              count;
    logic                         term;
  } u16u8_res_t;

endpackage

// ----- rtl/core/u16u8_encoder.sv -----
// ----------------------------------------------------------------------------
// u16u8_encoder
// Pairs surrogates, applies the byte budget and builds the UTF-8 byte group.
// ----------------------------------------------------------------------------
module u16u8_encoder
  import u16u8_pkg::*;
(
  input  u16u8_item_t  item_i,
  input  u16u8_state_t state_i,
  input  logic [CapW-1:0] capacity_i,
  output u16u8_state_t state_o,
  output u16u8_res_t   res_o
);

  logic [CpW-1:0]               cp;
  logic                         have_char;
  logic                         do_enc;
  logic [BudgetW-1:0]           budget_start;
  logic [BudgetW-1:0]           budget_mid;
  logic [BudgetW-1:0]           capped;
  logic [CntW-1:0]              n_char;
  logic [MaxChar-1:0][ByteW-1:0] chb;

  always_comb begin
    if (32'(capacity_i) > 32'(BudgetMax)) begin
      capped = BudgetMax;
    end else begin
      capped = BudgetW'(capacity_i);
    end
  end

  always_comb begin
    cp        = '0;
    have_char = 1'b0;
    state_o   = state_i;
    budget_start = item_i.reload_budget ? capped : state_i.budget;

    if (state_i.pend_valid) begin
      cp = PlaneBase + CpW'({state_i.pend_hi, item_i.code_unit[PayloadW-1:0]});
      state_o.pend_valid = 1'b0;
      state_o.pend_hi    = '0;
      have_char          = 1'b1;
    end else if (item_i.code_unit[15:8] >= SurrFirst && item_i.code_unit[15:8] < SurrEnd) begin
      // Hold any surrogate as a first half; drop it on the last unit
      if (!item_i.last_unit) begin
        state_o.pend_hi    = item_i.code_unit[PayloadW-1:0];
        state_o.pend_valid = 1'b1;
      end
    end else begin
      cp        = CpW'(item_i.code_unit);
      have_char = 1'b1;
    end

    do_enc = have_char && (budget_start > BudgetFloor);

    chb = '0;
    priority if (cp <= Max1Byte) begin
      n_char = CntW'(1);
      chb[0] = cp[7:0];
    end else if (cp <= Max2Byte) begin
      n_char = CntW'(2);
      chb[0] = Lead2 | {3'b000, cp[10:6]};
      chb[1] = ContMark | {2'b00, cp[5:0]};
    end else if (cp <= Max3Byte) begin
      n_char = CntW'(3);
      chb[0] = Lead3 | {4'b0000, cp[15:12]};
      chb[1] = ContMark | {2'b00, cp[11:6]};
      chb[2] = ContMark | {2'b00, cp[5:0]};
    end else begin
      n_char = CntW'(4);
      chb[0] = Lead4 | {5'b00000, cp[20:18]};
      chb[1] = ContMark | {2'b00, cp[17:12]};
      chb[2] = ContMark | {2'b00, cp[11:6]};
      chb[3] = ContMark | {2'b00, cp[5:0]};
    end

    if (!do_enc) begin
      n_char = '0;
      chb    = '0;
    end

    budget_mid = budget_start - BudgetW'(n_char);
    if (item_i.last_unit && budget_mid != '0) begin
      state_o.budget = budget_mid - BudgetW'(1);
    end else begin
      state_o.budget = budget_mid;
    end

    // Terminator slot right after the character bytes is already zero
    res_o.bytes = {{ByteW{1'b0}}, chb};
    res_o.count = n_char + CntW'(item_i.last_unit);
    res_o.term  = item_i.last_unit;
  end

endmodule

// ----- rtl/core/u16u8_emitter.sv -----
// ----------------------------------------------------------------------------
// u16u8_emitter
// Result register for one byte group; shifts one byte out per transfer.
// ----------------------------------------------------------------------------
module u16u8_emitter
  import u16u8_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  u16u8_res_t res_i,
  output logic       free_o,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] out_byte
  output logic       m_axis_tuser_o,  // [0] is_terminator
  output logic       m_axis_tlast_o   // last_of_run
);

  logic [MaxRes-1:0][ByteW-1:0] bytes_q, bytes_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic                         term_q, term_d;
  logic                         xfer;

  assign xfer   = m_axis_tvalid_o && m_axis_tready_i;
  assign free_o = (cnt_q == '0) || (cnt_q == CntW'(1) && m_axis_tready_i);

  always_comb begin
    bytes_d = bytes_q;
    cnt_d   = cnt_q;
    term_d  = term_q;
    if (load_i) begin
      bytes_d = res_i.bytes;
      cnt_d   = res_i.count;
      term_d  = res_i.term;
    end else if (xfer) begin
      bytes_d = {{ByteW{1'b0}}, bytes_q[MaxRes-1:1]};
      cnt_d   = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      term_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      term_q <= term_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tdata_o  = bytes_q[0];
  assign m_axis_tlast_o  = (cnt_q == CntW'(1));
  assign m_axis_tuser_o  = term_q && (cnt_q == CntW'(1));

  // The terminator always closes its run and carries a zero byte
  a_term_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o && m_axis_tdata_o == 8'h00)
    else $error("terminator not last or not zero");

  // A group is never replaced while bytes that cannot leave remain
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> cnt_q == '0 || (cnt_q == CntW'(1) && m_axis_tready_i))
    else $error("result group overwritten");

endmodule

// ----- rtl/core/utf16le_to_utf8_transcoder.sv -----
// ----------------------------------------------------------------------------
// utf16le_to_utf8_transcoder
// UTF-16LE code units in, UTF-8 bytes out, with an output byte budget.
// ----------------------------------------------------------------------------
// Each transfer on the slave side carries one UTF-16 code unit. A surrogate
// unit (high byte D8-DF) with nothing pending is held as the first half of a
// pair (or dropped if it is the last unit), and whatever unit follows
// completes it using its low 10 bits. Every completed character is encoded
// to 1-4 UTF-8 bytes while the remaining budget exceeds 6 and is dropped
// otherwise; tlast on the input appends a NUL terminator (tuser high on the
// output) and takes one more from the budget, saturating at zero. tuser on
// the input reloads the budget from the capacity register before the unit is
// handled. The unit sits in an input register, is encoded in one pass of
// logic and lands in a result register whose bytes leave one per cycle while
// the output is ready. A unit yields 0 to 5 bytes, and one that yields none
// takes no output transfer. The input register can hold the next unit while
// a group drains, and a new unit is taken in the same cycle the last byte of
// the previous group is transferred.
// ----------------------------------------------------------------------------
module utf16le_to_utf8_transcoder
  import u16u8_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [11:0] cfg_wr_data_i,    // buffer_capacity
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] code_unit
  input  logic        s_axis_tlast_i,   // last_unit
  input  logic        s_axis_tuser_i,   // [0] reload_budget
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic        m_axis_tuser_o,   // [0] is_terminator
  output logic        m_axis_tlast_o    // last_of_run
);

  logic         in_valid_q, in_valid_d;
  u16u8_item_t  item_q, item_d;
  u16u8_state_t state_q, state_d;
  logic [CapW-1:0] cap_q, cap_d;
  u16u8_state_t state_nxt;
  u16u8_res_t   res;
  logic         res_free;
  logic         load;
  logic         in_xfer;

  // Encode the held unit once the result register can take its group
  assign load            = in_valid_q && res_free;
  assign s_axis_tready_o = !in_valid_q || load;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    item_d     = item_q;
    if (in_xfer) begin
      in_valid_d           = 1'b1;
      item_d.code_unit     = s_axis_tdata_i;
      item_d.last_unit     = s_axis_tlast_i;
      item_d.reload_budget = s_axis_tuser_i;
    end else if (load) begin
      in_valid_d = 1'b0;
    end
  end

  assign state_d = load ? state_nxt : state_q;
  assign cap_d   = cfg_wr_en_i ? cfg_wr_data_i : cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q         <= 1'b0;
      state_q.pend_valid <= 1'b0;
      state_q.pend_hi    <= '0;
      state_q.budget     <= BudgetW'(CapReset);
      cap_q              <= CapReset;
    end else begin
      in_valid_q <= in_valid_d;
      state_q    <= state_d;
      cap_q      <= cap_d;
    end
  end

  // Payload of the input register: no reset
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  u16u8_encoder u_encoder (
    .item_i     (item_q),
    .state_i    (state_q),
    .capacity_i (cap_q),
    .state_o    (state_nxt),
    .res_o      (res)
  );

  u16u8_emitter u_emitter (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load),
    .res_i           (res),
    .free_o          (res_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Without a reload the budget can only shrink
  a_budget_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(load && item_q.reload_budget) |=> state_q.budget <= $past(state_q.budget))
    else $error("budget grew without reload");

  // A string end never leaves a half pair pending
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && item_q.last_unit |=> !state_q.pend_valid)
    else $error("pending half survived last unit");

endmodule

// ----- verif/tb_utf16le_to_utf8_transcoder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf16le_to_utf8_transcoder
// Self-checking bench for the UTF-16LE to UTF-8 transcoder. Code units go in
// on the slave stream, and an in-bench predictor works out the UTF-8 bytes,
// terminators and budget effects of each accepted unit. Every byte on the
// master stream is checked in order against those expectations. Both streams
// stall at random, and the capacity register is swept between phases.
// ----------------------------------------------------------------------------
module tb_utf16le_to_utf8_transcoder
  import u16u8_pkg::*;
;

  // One unit waiting to be sent; hold_for_drain stalls the sender until every
  // expected byte has come back.
  typedef struct {
    logic [UnitW-1:0] code;
    logic             last;
    logic             reload;
    logic             hold_for_drain;
  } unit_req_t;

  // One expected output byte with its flags.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             term;
    logic             last;
  } utf8_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_wr_en_i = 1'b0;
  logic [11:0] cfg_wr_data_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;

  utf16le_to_utf8_transcoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en_i),
    .cfg_wr_data_i   (cfg_wr_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Units still to send, and the UTF-8 bytes still owed by the block
  unit_req_t  unit_queue[$];
  utf8_beat_t utf8_expected[$];
  unit_req_t  next_unit;

  // Sender bookkeeping: a unit is outstanding while issued != taken
  int unsigned units_issued = 0;
  int unsigned units_taken = 0;
  int unsigned fail_count = 0;

  // When set, neither side idles (long stall-free stretch)
  logic steady = 1'b0;

  // Predictor state: mirrors the block's capacity, pending half and budget
  logic [CapW-1:0]     model_capacity = CapReset;
  logic                model_pend_valid = 1'b0;
  logic [PayloadW-1:0] model_pend_hi = '0;
  logic [BudgetW-1:0]  model_budget = BudgetW'(CapReset);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor: advance the mirrored state by one accepted unit and queue the
  // bytes it must produce.
  // --------------------------------------------------------------------------
  task automatic transcode_unit(input logic [UnitW-1:0] code, input logic last,
                                input logic reload);
    logic [CpW-1:0] cp;
    logic           have_char;
    utf8_beat_t     run_q[$];
    cp = '0;
    have_char = 1'b0;
    // The capacity is 12 bits wide, so it never exceeds the budget cap.
    if (reload) model_budget = model_capacity;
    if (model_pend_valid) begin
      // Whatever follows a held half completes it, using its low 10 bits
      cp = PlaneBase + CpW'({model_pend_hi, code[PayloadW-1:0]});
      model_pend_valid = 1'b0;
      model_pend_hi = '0;
      have_char = 1'b1;
    end else if (code[15:8] >= SurrFirst && code[15:8] < SurrEnd) begin
      // Hold any surrogate as a first half, unless the string ends here
      if (!last) begin
        model_pend_hi = code[PayloadW-1:0];
        model_pend_valid = 1'b1;
      end
    end else begin
      cp = CpW'(code);
      have_char = 1'b1;
    end
    if (have_char && model_budget > BudgetFloor) begin
      if (cp <= Max1Byte) begin
        run_q.push_back('{cp[7:0], 1'b0, 1'b0});
      end else if (cp <= Max2Byte) begin
        run_q.push_back('{Lead2 | {3'b0, cp[10:6]}, 1'b0, 1'b0});
        run_q.push_back('{ContMark | {2'b0, cp[5:0]}, 1'b0, 1'b0});
      end else if (cp <= Max3Byte) begin
        run_q.push_back('{Lead3 | {4'b0, cp[15:12]}, 1'b0, 1'b0});
        run_q.push_back('{ContMark | {2'b0, cp[11:6]}, 1'b0, 1'b0});
        run_q.push_back('{ContMark | {2'b0, cp[5:0]}, 1'b0, 1'b0});
      end else begin
        run_q.push_back('{Lead4 | {5'b0, cp[20:18]}, 1'b0, 1'b0});
        run_q.push_back('{ContMark | {2'b0, cp[17:12]}, 1'b0, 1'b0});
        run_q.push_back('{ContMark | {2'b0, cp[11:6]}, 1'b0, 1'b0});
        run_q.push_back('{ContMark | {2'b0, cp[5:0]}, 1'b0, 1'b0});
      end
      model_budget = model_budget - BudgetW'(run_q.size());
    end
    if (last) begin
      // Terminator always goes out; the budget saturates at zero
      run_q.push_back('{8'h00, 1'b1, 1'b0});
      if (model_budget != '0) model_budget = model_budget - 1'b1;
    end
    if (run_q.size() != 0) run_q[run_q.size() - 1].last = 1'b1;
    foreach (run_q[i]) utf8_expected.push_back(run_q[i]);
  endtask

  // --------------------------------------------------------------------------
  // Sender: at each falling edge, hold an unaccepted unit; otherwise idle at
  // random or present the next one from the queue.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && units_issued == units_taken) begin
      if (unit_queue.size() == 0 || (!steady && $urandom_range(99) < 23) ||
          (unit_queue[0].hold_for_drain && utf8_expected.size() != 0)) begin
        s_axis_tvalid_i <= 1'b0;
      end else begin
        next_unit = unit_queue.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= next_unit.code;
        s_axis_tlast_i  <= next_unit.last;
        s_axis_tuser_i  <= next_unit.reload;
        units_issued    <= units_issued + 1;
      end
    end
  end

  // Receiver: drop ready in about a quarter of the cycles unless steady
  always @(negedge clk_i) begin
    m_axis_tready_i <= steady || ($urandom_range(99) >= 23);
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on each input transfer, check each output transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        transcode_unit(s_axis_tdata_i, s_axis_tlast_i, s_axis_tuser_i);
        units_taken <= units_taken + 1;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (utf8_expected.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected byte data=%02h term=%0b last=%0b", $time,
                   m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        end else begin
          if (m_axis_tdata_o !== utf8_expected[0].data ||
              m_axis_tuser_o !== utf8_expected[0].term ||
              m_axis_tlast_o !== utf8_expected[0].last) begin
            fail_count++;
            $display({"%0t: mismatch expected data=%02h term=%0b last=%0b,",
                      " got data=%02h term=%0b last=%0b"},
                     $time, utf8_expected[0].data, utf8_expected[0].term,
                     utf8_expected[0].last, m_axis_tdata_o, m_axis_tuser_o,
                     m_axis_tlast_o);
          end
          void'(utf8_expected.pop_front());
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_unit(input logic [UnitW-1:0] code, input logic last = 1'b0,
                           input logic reload = 1'b0, input logic hold = 1'b0);
    unit_req_t r;
    r.code = code;
    r.last = last;
    r.reload = reload;
    r.hold_for_drain = hold;
    unit_queue.push_back(r);
  endtask

  // Wait until every unit is sent and every byte is back, then let the block
  // finish any unit that yields nothing.
  task automatic wait_quiet();
    while (unit_queue.size() != 0 || units_issued != units_taken ||
           utf8_expected.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] value);
    wait_quiet();
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    model_capacity = value;
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b0;
  endtask

  // Mostly well-formed text: ASCII, 2- and 3-byte characters and surrogate
  // pairs, with some raw noise that breaks pairs up.
  task automatic queue_random_units(input int count);
    int          sent;
    int unsigned pick;
    logic [15:0] code;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        code = 16'($urandom_range(16'h007F));
      end else if (pick < 55) begin
        code = 16'($urandom_range(16'h07FF, 16'h0080));
      end else if (pick < 75) begin
        do code = 16'($urandom_range(16'hFFFF, 16'h0800));
        while (code[15:8] >= SurrFirst && code[15:8] < SurrEnd);
      end else if (pick < 90) begin
        // High half; now and then cut the pair off with tlast
        push_unit(16'($urandom_range(16'hDBFF, 16'hD800)),
                  $urandom_range(19) == 0, $urandom_range(11) == 0);
        sent++;
        code = 16'($urandom_range(16'hDFFF, 16'hDC00));
      end else begin
        code = 16'($urandom_range(16'hFFFF));
      end
      push_unit(code, $urandom_range(9) == 0, $urandom_range(11) == 0);
      sent++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence of phases
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Code point boundaries at the reset capacity
    push_unit(16'h0000);
    push_unit(16'h007F);
    push_unit(16'h0080);
    push_unit(16'h07FF);
    push_unit(16'h0800);
    push_unit(16'hD7FF);
    push_unit(16'hE000);
    push_unit(16'hFFFF);
    // Lowest and highest supplementary characters
    push_unit(16'hD800);
    push_unit(16'hDC00);
    push_unit(16'hDBFF);
    push_unit(16'hDFFF);
    // Low surrogate taken as the first half
    push_unit(16'hDC05);
    push_unit(16'hDE00);
    // Non-surrogate unit completing a pair
    push_unit(16'hD83D);
    push_unit(16'h0041);
    // Pair cut off by the end of the string
    push_unit(16'hD812, 1'b1);
    // Reload while a half is held: the half is kept and this unit completes it
    push_unit(16'hD800);
    push_unit(16'hDC01, 1'b0, 1'b1);
    // Four bytes plus terminator from one unit
    push_unit(16'hD801);
    push_unit(16'hDC02, 1'b1);
    push_unit(16'h00E9, 1'b1);

    // Smallest legal capacity: exhaust the budget, then saturate it at zero
    write_capacity(12'd7);
    push_unit(16'h0041, 1'b0, 1'b1);
    push_unit(16'h0042);
    push_unit(16'h20AC, 1'b1);
    push_unit(16'hD800, 1'b0, 1'b1);
    push_unit(16'hDC00);
    repeat (4) push_unit(16'h0043, 1'b1);

    // Capacity below the floor drops every character
    write_capacity(12'd0);
    push_unit(16'h0044, 1'b1, 1'b1);

    // Largest capacity with no idling on either side
    write_capacity(12'd4095);
    steady = 1'b1;
    push_unit(16'h0045, 1'b0, 1'b1);
    queue_random_units(40);
    wait_quiet();
    steady = 1'b0;

    // Random capacity; pause the sender midway until all bytes are back
    write_capacity(12'($urandom_range(4095, 7)));
    push_unit(16'h0046, 1'b0, 1'b1);
    queue_random_units(30);
    push_unit(16'h0047, 1'b0, 1'b0, 1'b1);
    queue_random_units(30);

    // Tight budget so characters get dropped often
    write_capacity(12'($urandom_range(40, 7)));
    push_unit(16'h0048, 1'b0, 1'b1);
    queue_random_units(60);

    // Near the floor, crossing it on reload
    write_capacity(12'($urandom_range(10, 5)));
    push_unit(16'h0049, 1'b0, 1'b1);
    queue_random_units(40);

    wait_quiet();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && utf8_expected.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
